FILE: rtl/core/csv_row_boundary_finder_core_defines.svh
// Assertion macros for the CSV row boundary finder core.
`ifndef CSV_ROW_BOUNDARY_FINDER_CORE_DEFINES_SVH
`define CSV_ROW_BOUNDARY_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRBF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRBF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/crbf_pkg.sv
package crbf_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Request kinds carried on req_tuser
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Default depth of the queue between front and back
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [2:0] {
      MODE_UNQ    = 3'd0,
      MODE_QUO    = 3'd1,
      MODE_QEND   = 3'd2,
      MODE_LFHELD = 3'd3,
      MODE_CRSEEN = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       row_end;
      logic       stream_end;
      logic       last_of_run;
   } result_type;

   // One queue entry: the one or two results caused by one request
   typedef struct packed {
      result_type res0;
      result_type res1;
      logic       two;
   } entry_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      mode_type   mode;
   } unq_type;

   // Handle a byte at the start of, or inside, an unquoted field
   function automatic unq_type unq_step(input logic [7:0] b, input logic cr_ends);
      unq_type r;
      r.emit = 1'b1;
      r.res  = '{out_byte: b, row_end: 1'b0, stream_end: 1'b0, last_of_run: 1'b1};
      r.mode = MODE_UNQ;
      if (b == CH_QUOTE) begin
         r.mode = MODE_QUO;
      end else if (b == CH_LF) begin
         r.emit = 1'b0;
         r.mode = MODE_LFHELD;
      end else if (b == CH_CR) begin
         if (cr_ends) begin
            r.res.row_end = 1'b1;
         end else begin
            r.mode = MODE_CRSEEN;
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/csv_row_boundary_finder_core.sv
// A result passes from the front through the front-to-back queue into the output register;
// a line feed outside quotes is held until the next request decides its row end.
// Throughput: one request per cycle and, while rsp_tready is high, one result per cycle;
// two-result requests are absorbed by the queue, which stalls req_tready only when full.
// Reset: synchronous, active high; clears mode, queue count, valid bits, cr_ends_row to 0.
`include "csv_row_boundary_finder_core_defines.svh"
module csv_row_boundary_finder_core import crbf_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_we,
   input  logic       csr_wdata,   // cr_ends_row
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] command
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] row_end, [1] stream_end
   output logic       rsp_tlast    // last_of_run
);

   logic       cr_ends_row_ff;
   logic       accept;
   logic       push;
   logic       pop;
   logic       empty;
   logic       full;
   entry_type  push_entry;
   entry_type  head;
   mode_type   mode;
   result_type rsp_result;

   // Capture the CR option
   always_ff @(posedge clock) begin
      if (reset) begin
         cr_ends_row_ff <= 1'b0;
      end else if (csr_we) begin
         cr_ends_row_ff <= csr_wdata;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   crbf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cr_ends_row (cr_ends_row_ff),
      .accept      (accept),
      .command     (req_tuser),
      .in_byte     (req_tdata),
      .push        (push),
      .entry       (push_entry),
      .mode        (mode)
   );

   crbf_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   crbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.out_byte;
   assign rsp_tuser = {rsp_result.stream_end, rsp_result.row_end};
   assign rsp_tlast = rsp_result.last_of_run;

   // End marker is never a row end and always closes its run
   `CRBF_ASSERT_NOW(a_marker_shape, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0] && rsp_tlast, "end marker malformed")
   // Queue never overflows
   `CRBF_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
   // End of input returns the parser to unquoted
   `CRBF_ASSERT_NEXT(a_end_resets_mode, accept && (req_tuser == CMD_END), mode == MODE_UNQ, "mode not cleared at end")

endmodule

FILE: rtl/core/crbf_front.sv
module crbf_front import crbf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cr_ends_row,
   input  logic       accept,
   input  logic       command,
   input  logic [7:0] in_byte,
   output logic       push,
   output entry_type  entry,
   output mode_type   mode
);

   mode_type mode_ff, mode_in;
   unq_type  unq;
   logic     emit;

   // Classify the request against the current mode
   always_comb begin
      unq     = unq_step(in_byte, cr_ends_row);
      mode_in = mode_ff;
      emit    = 1'b0;
      entry   = '0;
      if (command == CMD_END) begin
         emit    = 1'b1;
         mode_in = MODE_UNQ;
         if (mode_ff == MODE_LFHELD) begin
            entry.res0 = '{out_byte: CH_LF, row_end: 1'b1, stream_end: 1'b0,
                           last_of_run: 1'b0};
            entry.res1 = '{out_byte: 8'h00, row_end: 1'b0, stream_end: 1'b1,
                           last_of_run: 1'b1};
            entry.two  = 1'b1;
         end else begin
            entry.res0 = '{out_byte: 8'h00, row_end: 1'b0, stream_end: 1'b1,
                           last_of_run: 1'b1};
         end
      end else begin
         unique case (mode_ff)
            MODE_QUO: begin
               emit       = 1'b1;
               entry.res0 = '{out_byte: in_byte, row_end: 1'b0, stream_end: 1'b0,
                              last_of_run: 1'b1};
               if (in_byte == CH_QUOTE) begin
                  mode_in = MODE_QEND;
               end
            end
            MODE_QEND: begin
               if (in_byte == CH_QUOTE) begin
                  emit       = 1'b1;
                  entry.res0 = '{out_byte: in_byte, row_end: 1'b0, stream_end: 1'b0,
                                 last_of_run: 1'b1};
                  mode_in    = MODE_QUO;
               end else begin
                  emit       = unq.emit;
                  entry.res0 = unq.res;
                  mode_in    = unq.mode;
               end
            end
            MODE_LFHELD: begin
               emit = 1'b1;
               if (in_byte == CH_CR) begin
                  entry.res0 = '{out_byte: CH_LF, row_end: 1'b0, stream_end: 1'b0,
                                 last_of_run: 1'b0};
                  entry.res1 = '{out_byte: CH_CR, row_end: 1'b1, stream_end: 1'b0,
                                 last_of_run: 1'b1};
                  entry.two  = 1'b1;
                  mode_in    = MODE_UNQ;
               end else begin
                  // release the held LF, then handle the byte on a new row
                  entry.res0 = '{out_byte: CH_LF, row_end: 1'b1, stream_end: 1'b0,
                                 last_of_run: !unq.emit};
                  entry.res1 = unq.res;
                  entry.two  = unq.emit;
                  mode_in    = unq.mode;
               end
            end
            MODE_CRSEEN: begin
               if (in_byte == CH_LF) begin
                  emit       = 1'b1;
                  entry.res0 = '{out_byte: in_byte, row_end: 1'b1, stream_end: 1'b0,
                                 last_of_run: 1'b1};
                  mode_in    = MODE_UNQ;
               end else begin
                  emit       = unq.emit;
                  entry.res0 = unq.res;
                  mode_in    = unq.mode;
               end
            end
            default: begin
               emit       = unq.emit;
               entry.res0 = unq.res;
               mode_in    = unq.mode;
            end
         endcase
      end
      push = accept && emit;
   end

   // Advance the parse mode on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNQ;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   assign mode = mode_ff;

endmodule

FILE: rtl/core/crbf_fifo.sv
module crbf_fifo import crbf_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = mem[rd_ptr_ff];

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/crbf_back.sv
module crbf_back import crbf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   logic       load;

   // Pick the next result: a held second result first, then the queue head
   always_comb begin
      load          = !out_valid_ff || rsp_ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      pop           = 1'b0;
      if (load) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = hold_ff;
            hold_valid_in = 1'b0;
         end else if (!empty) begin
            pop           = 1'b1;
            out_valid_in  = 1'b1;
            out_in        = head.res0;
            hold_valid_in = head.two;
            hold_in       = head.res1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule
